[hdl/cmpd_pkg.sv]
// shared types, sizes and float helpers for the complex matrix product diagonal
package cmpd_pkg;

    localparam int SIZE   = 4;
    localparam int CELLS  = SIZE * SIZE;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W  = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int CNT_W  = $clog2(2 * CELLS);
    localparam int ELEM_W = 64;
    localparam int FP_W   = 32;

    localparam logic [FP_W-1:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [FP_W-1:0] QUIET_BIT    = 32'h0040_0000;

    typedef struct packed {
        logic            start;
        logic            sub;
        logic [FP_W-1:0] a;
        logic [FP_W-1:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic            done;
        logic [FP_W-1:0] res;
    } fpu_rsp_t;

    function automatic logic is_nan(input logic [FP_W-1:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [FP_W-1:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [FP_W-1:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // significand with hidden bit
    function automatic logic [23:0] mant(input logic [FP_W-1:0] x);
        return {x[30:23] != 8'd0, x[22:0]};
    endfunction

    // subnormals use exponent one
    function automatic logic [7:0] exp_eff(input logic [FP_W-1:0] x);
        return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    endfunction

    // round to nearest even and pack; e >= 1, m[23] clear only when e == 1
    function automatic logic [FP_W-1:0] round_pack(input logic sign,
                                                   input logic signed [10:0] e,
                                                   input logic [23:0] m,
                                                   input logic g,
                                                   input logic st);
        logic                rnd;
        logic [24:0]         m25;
        logic [23:0]         mm;
        logic signed [10:0]  ee;
        logic [FP_W-1:0]     r;
        rnd = g & (st | m[0]);
        m25 = {1'b0, m} + {24'd0, rnd};
        if (m25[24])
        begin
            mm = m25[24:1];
            ee = e + 11'sd1;
        end
        else
        begin
            mm = m25[23:0];
            ee = e;
        end
        if (ee >= 11'sd255)
            r = {sign, 8'hFF, 23'd0};
        else if (mm[23])
            r = {sign, ee[7:0], mm[22:0]};
        else
            r = {sign, 8'd0, mm[22:0]};
        return r;
    endfunction

endpackage

[hdl/cmpd_ram.sv]
// generic single-port-write, registered-read ram
module cmpd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[hdl/cmpd_fmul.sv]
// multi-cycle single precision multiplier, round to nearest even
module cmpd_fmul (
    input  logic               clk,
    input  logic               rst_n,
    input  cmpd_pkg::fpu_req_t req,
    output cmpd_pkg::fpu_rsp_t rsp
);
    import cmpd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_NORM, ST_RND, ST_FIN} state_t;

    state_t             state_reg, state_next;
    logic [47:0]        p_reg, p_next;
    logic signed [10:0] e_reg, e_next;
    logic               stk_reg, stk_next;
    logic               sign_reg, sign_next;
    logic [FP_W-1:0]    res_reg, res_next;
    logic [23:0]        ma, mb;
    logic [7:0]         ea, eb;

    assign ma = mant(req.a);
    assign mb = mant(req.b);
    assign ea = exp_eff(req.a);
    assign eb = exp_eff(req.b);

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        e_next     = e_reg;
        stk_next   = stk_reg;
        sign_next  = sign_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    sign_next  = req.a[31] ^ req.b[31];
                    state_next = ST_FIN;
                    if (is_nan(req.a))
                        res_next = req.a | QUIET_BIT;
                    else if (is_nan(req.b))
                        res_next = req.b | QUIET_BIT;
                    else if ((is_inf(req.a) && is_zero(req.b)) ||
                             (is_zero(req.a) && is_inf(req.b)))
                        res_next = QNAN_DEFAULT;
                    else if (is_inf(req.a) || is_inf(req.b))
                        res_next = {req.a[31] ^ req.b[31], 8'hFF, 23'd0};
                    else if (is_zero(req.a) || is_zero(req.b))
                        res_next = {req.a[31] ^ req.b[31], 31'd0};
                    else
                    begin
                        p_next     = ma * mb;
                        e_next     = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
                        stk_next   = 1'b0;
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM:
            begin
                if (!p_reg[47] && (e_reg > 11'sd1))
                begin
                    p_next = {p_reg[46:0], 1'b0};
                    e_next = e_reg - 11'sd1;
                end
                else if (e_reg < 11'sd1)
                begin
                    // everything shifts out below the guard bit
                    if (e_reg < -11'sd48)
                    begin
                        stk_next = stk_reg | (|p_reg);
                        p_next   = '0;
                        e_next   = 11'sd1;
                    end
                    else
                    begin
                        stk_next = stk_reg | p_reg[0];
                        p_next   = {1'b0, p_reg[47:1]};
                        e_next   = e_reg + 11'sd1;
                    end
                end
                else
                    state_next = ST_RND;
            end
            ST_RND:
            begin
                res_next   = round_pack(sign_reg, e_reg, p_reg[47:24], p_reg[23],
                                        (|p_reg[22:0]) | stk_reg);
                state_next = ST_FIN;
            end
            ST_FIN:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        e_reg    <= e_next;
        stk_reg  <= stk_next;
        sign_reg <= sign_next;
        res_reg  <= res_next;
    end

    assign rsp.done = (state_reg == ST_FIN);
    assign rsp.res  = res_reg;

endmodule

[hdl/cmpd_fadd.sv]
// multi-cycle single precision adder / subtractor, round to nearest even
module cmpd_fadd (
    input  logic               clk,
    input  logic               rst_n,
    input  cmpd_pkg::fpu_req_t req,
    output cmpd_pkg::fpu_rsp_t rsp
);
    import cmpd_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_SUM, ST_NORM, ST_RND, ST_FIN} state_t;

    state_t             state_reg, state_next;
    logic [26:0]        mx_reg, mx_next;
    logic [26:0]        ms_reg, ms_next;
    logic [27:0]        s_reg, s_next;
    logic signed [10:0] e_reg, e_next;
    logic               sign_reg, sign_next;
    logic               eff_sub_reg, eff_sub_next;
    logic [FP_W-1:0]    res_reg, res_next;

    logic [FP_W-1:0]    b_eff, big, small_op;
    logic               swap;
    logic [7:0]         e_big, e_small, d;
    logic [26:0]        ms_x, shifted;
    logic               lost;

    assign b_eff    = req.b ^ {req.sub, 31'd0};
    assign swap     = b_eff[30:0] > req.a[30:0];
    assign big      = swap ? b_eff : req.a;
    assign small_op = swap ? req.a : b_eff;
    assign e_big    = exp_eff(big);
    assign e_small  = exp_eff(small_op);
    assign d        = e_big - e_small;
    assign ms_x     = {mant(small_op), 3'b000};
    assign shifted  = (d >= 8'd27) ? 27'd0 : (ms_x >> d);
    assign lost     = (d >= 8'd27) ? 1'b1 : |(ms_x & ((27'd1 << d) - 27'd1));

    always_comb
    begin
        state_next   = state_reg;
        mx_next      = mx_reg;
        ms_next      = ms_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        sign_next    = sign_reg;
        eff_sub_next = eff_sub_reg;
        res_next     = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    state_next = ST_FIN;
                    if (is_nan(req.a))
                        res_next = req.a | QUIET_BIT;
                    else if (is_nan(req.b))
                        res_next = req.b | QUIET_BIT;
                    else if (is_inf(req.a) && is_inf(b_eff) && (req.a[31] != b_eff[31]))
                        res_next = QNAN_DEFAULT;
                    else if (is_inf(req.a))
                        res_next = req.a;
                    else if (is_inf(b_eff))
                        res_next = b_eff;
                    else if (is_zero(req.a) && is_zero(b_eff))
                        res_next = {req.a[31] & b_eff[31], 31'd0};
                    else if (is_zero(req.a))
                        res_next = b_eff;
                    else if (is_zero(b_eff))
                        res_next = req.a;
                    else
                    begin
                        mx_next      = {mant(big), 3'b000};
                        ms_next      = shifted | {26'd0, lost};
                        e_next       = $signed({3'b000, e_big});
                        sign_next    = big[31];
                        eff_sub_next = req.a[31] ^ b_eff[31];
                        state_next   = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                s_next     = eff_sub_reg ? ({1'b0, mx_reg} - {1'b0, ms_reg})
                                         : ({1'b0, mx_reg} + {1'b0, ms_reg});
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (s_reg == 28'd0)
                begin
                    // exact cancellation gives plus zero
                    res_next   = '0;
                    state_next = ST_FIN;
                end
                else if (s_reg[27])
                begin
                    s_next = {1'b0, s_reg[27:2], s_reg[1] | s_reg[0]};
                    e_next = e_reg + 11'sd1;
                end
                else if (!s_reg[26] && (e_reg > 11'sd1))
                begin
                    s_next = {s_reg[26:0], 1'b0};
                    e_next = e_reg - 11'sd1;
                end
                else
                    state_next = ST_RND;
            end
            ST_RND:
            begin
                res_next   = round_pack(sign_reg, e_reg, s_reg[26:3], s_reg[2],
                                        s_reg[1] | s_reg[0]);
                state_next = ST_FIN;
            end
            ST_FIN:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mx_reg      <= mx_next;
        ms_reg      <= ms_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        sign_reg    <= sign_next;
        eff_sub_reg <= eff_sub_next;
        res_reg     <= res_next;
    end

    assign rsp.done = (state_reg == ST_FIN);
    assign rsp.res  = res_reg;

endmodule

[hdl/complex_matrix_product_diagonal.sv]
// top level: loads A and B into rams, then walks the diagonal of A times B
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | sink      | in_valid / in_ready | real_in, imag_in (float bits)
//  out     | source    | out_valid/out_ready | real_out, imag_out, last_out
//
// loading takes one item per cycle while in_valid is high, 2*SIZE*SIZE items per
// run; the last item of B starts the compute phase, during which in_ready is low.
// compute: per term one ram read plus four multiplies and four adds on one
// shared multiplier and one shared adder; each operation passes through an
// issue state and then waits for its unit, whose normalize loops shift one
// bit per cycle; special operands skip those loops.
// each diagonal entry goes into the output register; a row waits only if the
// previous entry has not been taken yet. after the last entry the block loads
// again while that entry still waits in the output register.
// reset clears the load counter and control state; ram contents are undefined.
module complex_matrix_product_diagonal (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] real_in,
    input  logic [31:0] imag_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] real_out,
    output logic [31:0] imag_out,
    output logic        last_out
);
    import cmpd_pkg::*;

    typedef enum logic [2:0] {ST_LOAD, ST_READ, ST_ISSUE, ST_WAIT, ST_OUT} state_t;

    // operation sequence for one term
    typedef enum logic [2:0] {
        STEP_RR,    // ar * br
        STEP_II,    // ai * bi
        STEP_RI,    // ar * bi
        STEP_IR,    // ai * br
        STEP_SRE,   // ar*br - ai*bi
        STEP_SIM,   // ar*bi + ai*br
        STEP_ARE,   // real accumulate
        STEP_AIM    // imaginary accumulate
    } step_t;

    localparam logic [CNT_W-1:0]  LOAD_LAST = CNT_W'(2 * CELLS - 1);
    localparam logic [CNT_W-1:0]  CELLS_C   = CNT_W'(CELLS);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SIZE - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SIZE);

    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    logic [CNT_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [ADDR_W-1:0] a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;
    logic [FP_W-1:0]   p1_reg, p1_next;
    logic [FP_W-1:0]   p2_reg, p2_next;
    logic [FP_W-1:0]   p3_reg, p3_next;
    logic [FP_W-1:0]   p4_reg, p4_next;
    logic [FP_W-1:0]   acc_re_reg, acc_re_next;
    logic [FP_W-1:0]   acc_im_reg, acc_im_next;
    logic              out_valid_reg, out_valid_next;
    logic [FP_W-1:0]   real_out_reg, real_out_next;
    logic [FP_W-1:0]   imag_out_reg, imag_out_next;
    logic              last_out_reg, last_out_next;

    logic              in_fire;
    logic              a_we, b_we;
    logic [ADDR_W-1:0] b_waddr;
    logic [ELEM_W-1:0] elem;
    logic [ELEM_W-1:0] a_rdata, b_rdata;
    logic [FP_W-1:0]   ar, ai, br, bi;
    logic              step_mul;
    logic              unit_done;
    logic [FP_W-1:0]   unit_res;
    fpu_req_t          mul_req, add_req;
    fpu_rsp_t          mul_rsp, add_rsp;

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign elem     = {real_in, imag_in};

    // A fills the first CELLS items, B the rest
    assign a_we    = in_fire && (load_cnt_reg < CELLS_C);
    assign b_we    = in_fire && (load_cnt_reg >= CELLS_C);
    assign b_waddr = ADDR_W'(load_cnt_reg - CELLS_C);

    cmpd_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_first_matrix (
        .clk   (clk),
        .we    (a_we),
        .waddr (load_cnt_reg[ADDR_W-1:0]),
        .wdata (elem),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    cmpd_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_second_matrix (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (elem),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    // read data holds while addresses hold, so it serves all eight steps
    assign ar = a_rdata[63:32];
    assign ai = a_rdata[31:0];
    assign br = b_rdata[63:32];
    assign bi = b_rdata[31:0];

    assign step_mul = (step_reg == STEP_RR) || (step_reg == STEP_II) ||
                      (step_reg == STEP_RI) || (step_reg == STEP_IR);

    always_comb
    begin
        mul_req       = '0;
        add_req       = '0;
        mul_req.start = (state_reg == ST_ISSUE) && step_mul;
        add_req.start = (state_reg == ST_ISSUE) && !step_mul;
        unique case (step_reg)
            STEP_RR:  begin mul_req.a = ar; mul_req.b = br; end
            STEP_II:  begin mul_req.a = ai; mul_req.b = bi; end
            STEP_RI:  begin mul_req.a = ar; mul_req.b = bi; end
            STEP_IR:  begin mul_req.a = ai; mul_req.b = br; end
            STEP_SRE: begin add_req.a = p1_reg; add_req.b = p2_reg; add_req.sub = 1'b1; end
            STEP_SIM: begin add_req.a = p3_reg; add_req.b = p4_reg; end
            STEP_ARE: begin add_req.a = acc_re_reg; add_req.b = p1_reg; end
            STEP_AIM: begin add_req.a = acc_im_reg; add_req.b = p3_reg; end
            default:  begin mul_req.a = ar; mul_req.b = br; end
        endcase
    end

    cmpd_fmul u_fmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    cmpd_fadd u_fadd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (add_req),
        .rsp   (add_rsp)
    );

    assign unit_done = step_mul ? mul_rsp.done : add_rsp.done;
    assign unit_res  = step_mul ? mul_rsp.res : add_rsp.res;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        load_cnt_next  = load_cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        row_base_next  = row_base_reg;
        a_addr_next    = a_addr_reg;
        b_addr_next    = b_addr_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        p3_next        = p3_reg;
        p4_next        = p4_reg;
        acc_re_next    = acc_re_reg;
        acc_im_next    = acc_im_reg;
        real_out_next  = real_out_reg;
        imag_out_next  = imag_out_reg;
        last_out_next  = last_out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (load_cnt_reg == LOAD_LAST)
                    begin
                        // B complete: start row zero, column zero
                        load_cnt_next = '0;
                        row_next      = '0;
                        col_next      = '0;
                        row_base_next = '0;
                        a_addr_next   = '0;
                        b_addr_next   = '0;
                        acc_re_next   = '0;
                        acc_im_next   = '0;
                        state_next    = ST_READ;
                    end
                    else
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                end
            end
            ST_READ:
            begin
                step_next  = STEP_RR;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    unique case (step_reg)
                        STEP_RR:  p1_next = unit_res;
                        STEP_II:  p2_next = unit_res;
                        STEP_RI:  p3_next = unit_res;
                        STEP_IR:  p4_next = unit_res;
                        STEP_SRE: p1_next = unit_res;
                        STEP_SIM: p3_next = unit_res;
                        STEP_ARE: acc_re_next = unit_res;
                        STEP_AIM: acc_im_next = unit_res;
                        default:  p1_next = unit_res;
                    endcase
                    if (step_reg == STEP_AIM)
                    begin
                        if (col_reg == ROW_LAST)
                            state_next = ST_OUT;
                        else
                        begin
                            // next term: A along the row, B down the column
                            col_next    = col_reg + ROW_W'(1);
                            a_addr_next = a_addr_reg + ADDR_W'(1);
                            b_addr_next = b_addr_reg + ROW_STEP;
                            state_next  = ST_READ;
                        end
                    end
                    else
                    begin
                        step_next  = step_t'(step_reg + 3'd1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    real_out_next  = acc_re_reg;
                    imag_out_next  = acc_im_reg;
                    last_out_next  = (row_reg == ROW_LAST);
                    if (row_reg == ROW_LAST)
                        state_next = ST_LOAD;
                    else
                    begin
                        row_next      = row_reg + ROW_W'(1);
                        col_next      = '0;
                        row_base_next = row_base_reg + ROW_STEP;
                        a_addr_next   = row_base_reg + ROW_STEP;
                        b_addr_next   = ADDR_W'(row_reg) + ADDR_W'(1);
                        acc_re_next   = '0;
                        acc_im_next   = '0;
                        state_next    = ST_READ;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            step_reg      <= STEP_RR;
            load_cnt_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            row_base_reg  <= '0;
            a_addr_reg    <= '0;
            b_addr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            load_cnt_reg  <= load_cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            row_base_reg  <= row_base_next;
            a_addr_reg    <= a_addr_next;
            b_addr_reg    <= b_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        p3_reg       <= p3_next;
        p4_reg       <= p4_next;
        acc_re_reg   <= acc_re_next;
        acc_im_reg   <= acc_im_next;
        real_out_reg <= real_out_next;
        imag_out_reg <= imag_out_next;
        last_out_reg <= last_out_next;
    end

    assign out_valid = out_valid_reg;
    assign real_out  = real_out_reg;
    assign imag_out  = imag_out_reg;
    assign last_out  = last_out_reg;

    // the two float units never finish in the same cycle
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_rsp.done && add_rsp.done))
        else $error("multiplier and adder finished together");

    // a unit only reports back while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_rsp.done || add_rsp.done) |-> (state_reg == ST_WAIT))
        else $error("float unit done outside wait");

    // the last item of B closes the input until the diagonal is out
    a_load_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (load_cnt_reg == LOAD_LAST)) |=> !in_ready)
        else $error("input still open after last item of B");

    // a new result appears only from the output state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

endmodule
